[src/mvjs_pkg.sv]
// ----------------------------------------------------------------------------
// mvjs_pkg: shared types and constants
// joint motion vector solver: register codes, widths, stage payloads
// ----------------------------------------------------------------------------
`default_nettype none

package mvjs_pkg;

   // register indexes of the csr port
   localparam logic CSR_MIN_LENGTH_SQUARED = 1'b0;
   localparam logic CSR_MIN_SINE_Q16       = 1'b1;

   localparam logic [31:0] MIN_LENGTH_SQUARED_RESET = 32'd4096;
   localparam logic [15:0] MIN_SINE_Q16_RESET       = 16'd25035;

   localparam int OUT_W        = 20;  // q11.8 result width
   localparam int NUM_W        = 48;  // numerator magnitude width
   localparam int DEN_W        = 32;  // determinant magnitude width
   localparam int DIV_STAGES   = 10;
   localparam int DIV_STEPS    = 2;   // quotient bits resolved per stage
   localparam int REM_W        = NUM_W + 4;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   typedef struct packed {
      logic [31:0] min_length_squared;
      logic [15:0] min_sine_q16;
   } cfg_type;

   typedef struct packed {
      logic             ok;
      logic             neg_x;
      logic             neg_y;
      logic             ov_x;
      logic             ov_y;
      logic [NUM_W-1:0] num_x;
      logic [NUM_W-1:0] num_y;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             ok;
      logic             neg_x;
      logic             neg_y;
      logic             ov_x;
      logic             ov_y;
      logic [OUT_W-1:0] quo_x;
      logic [OUT_W-1:0] quo_y;
   } div_rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [OUT_W-1:0] quo;
   } div_lane_type;

   // two restoring steps; first quotient bit is at position top
   function automatic div_lane_type div_step(input div_lane_type cur,
                                             input logic [DEN_W-1:0] den,
                                             input int top);
      div_lane_type     res;
      logic [REM_W-1:0] trial;
      logic [REM_W-1:0] shifted;
      res = cur;
      for (int j = 0; j < DIV_STEPS; j++) begin
         shifted = {{(REM_W-DEN_W){1'b0}}, den} << (top - j);
         trial   = {{(REM_W-NUM_W){1'b0}}, res.rem};
         if (trial >= shifted) begin
            trial = trial - shifted;
            res.rem = trial[NUM_W-1:0];
            res.quo[top-j] = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[src/mvjs_front.sv]
// ----------------------------------------------------------------------------
// mvjs_front: product, determinant and rejection stages
// six register stages from the input vectors to the divider operands
// ----------------------------------------------------------------------------
`default_nettype none

module mvjs_front import mvjs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire logic               in_valid,
   output      logic               in_ready,
   input  wire logic signed [15:0] ax,
   input  wire logic signed [15:0] ay,
   input  wire logic signed [15:0] bx,
   input  wire logic signed [15:0] by,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      div_req_type        out_req
);

   localparam int NS = 6;

   logic [NS-1:0] v_ff;
   logic [NS-1:0] en;

   always_comb begin
      en[NS-1] = !v_ff[NS-1] || out_ready;
      for (int i = NS-2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // stage 1: square and cross products
   logic signed [15:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic signed [31:0] s1_axx_ff, s1_ayy_ff, s1_bxx_ff, s1_byy_ff, s1_c1_ff, s1_c2_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ax_ff  <= ax;
         s1_ay_ff  <= ay;
         s1_bx_ff  <= bx;
         s1_by_ff  <= by;
         s1_axx_ff <= ax * ax;
         s1_ayy_ff <= ay * ay;
         s1_bxx_ff <= bx * bx;
         s1_byy_ff <= by * by;
         s1_c1_ff  <= ax * by;
         s1_c2_ff  <= ay * bx;
      end
   end

   // stage 2: squared lengths, determinant, short check
   logic signed [15:0] s2_ax_ff, s2_ay_ff, s2_bx_ff, s2_by_ff;
   logic [31:0]        s2_sa_ff, s2_sb_ff;
   logic signed [32:0] s2_c_ff;
   logic               s2_bad_ff;
   logic [31:0]        s2_sa_in, s2_sb_in;

   assign s2_sa_in = {1'b0, s1_axx_ff[30:0]} + {1'b0, s1_ayy_ff[30:0]};
   assign s2_sb_in = {1'b0, s1_bxx_ff[30:0]} + {1'b0, s1_byy_ff[30:0]};

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_ax_ff  <= s1_ax_ff;
         s2_ay_ff  <= s1_ay_ff;
         s2_bx_ff  <= s1_bx_ff;
         s2_by_ff  <= s1_by_ff;
         s2_sa_ff  <= s2_sa_in;
         s2_sb_ff  <= s2_sb_in;
         s2_c_ff   <= {s1_c1_ff[31], s1_c1_ff} - {s1_c2_ff[31], s1_c2_ff};
         s2_bad_ff <= (s2_sa_in < cfg.min_length_squared) ||
                      (s2_sb_in < cfg.min_length_squared);
      end
   end

   // stage 3: wide products
   logic [32:0]        s3_cabs;
   logic [31:0]        s3_cmag_ff;
   logic [63:0]        s3_csq_ff, s3_sab_ff;
   logic [31:0]        s3_ksq_ff;
   logic signed [48:0] s3_t1_ff, s3_t2_ff, s3_t3_ff, s3_t4_ff;
   logic               s3_cneg_ff, s3_bad_ff;

   assign s3_cabs = s2_c_ff[32] ? 33'(-s2_c_ff) : s2_c_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_cmag_ff <= s3_cabs[31:0];
         s3_csq_ff  <= s3_cabs[31:0] * s3_cabs[31:0];
         s3_sab_ff  <= s2_sa_ff * s2_sb_ff;
         s3_ksq_ff  <= cfg.min_sine_q16 * cfg.min_sine_q16;
         s3_t1_ff   <= $signed({1'b0, s2_sa_ff}) * s2_by_ff;
         s3_t2_ff   <= $signed({1'b0, s2_sb_ff}) * s2_ay_ff;
         s3_t3_ff   <= $signed({1'b0, s2_sb_ff}) * s2_ax_ff;
         s3_t4_ff   <= $signed({1'b0, s2_sa_ff}) * s2_bx_ff;
         s3_cneg_ff <= s2_c_ff[32];
         s3_bad_ff  <= s2_bad_ff || (s2_c_ff == '0);
      end
   end

   // stage 4: numerators, threshold partial products
   logic signed [48:0] s4_nx_ff, s4_ny_ff;
   logic [63:0]        s4_rh0_ff;
   logic [61:0]        s4_rh1_ff;
   logic [63:0]        s4_csq_ff;
   logic [31:0]        s4_cmag_ff;
   logic               s4_cneg_ff, s4_bad_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_nx_ff   <= s3_t1_ff - s3_t2_ff;
         s4_ny_ff   <= s3_t3_ff - s3_t4_ff;
         s4_rh0_ff  <= s3_ksq_ff * s3_sab_ff[31:0];
         s4_rh1_ff  <= s3_ksq_ff * s3_sab_ff[61:32];
         s4_csq_ff  <= s3_csq_ff;
         s4_cmag_ff <= s3_cmag_ff;
         s4_cneg_ff <= s3_cneg_ff;
         s4_bad_ff  <= s3_bad_ff;
      end
   end

   // stage 5: threshold sum, magnitudes
   logic [95:0]        s5_rhs_ff, s5_lhs_ff;
   logic [48:0]        s5_nxa, s5_nya;
   logic [NUM_W-1:0]   s5_nx_ff, s5_ny_ff;
   logic [DEN_W-1:0]   s5_den_ff;
   logic               s5_negx_ff, s5_negy_ff, s5_bad_ff;

   assign s5_nxa = s4_nx_ff[48] ? 49'(-s4_nx_ff) : s4_nx_ff;
   assign s5_nya = s4_ny_ff[48] ? 49'(-s4_ny_ff) : s4_ny_ff;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_rhs_ff  <= {2'b0, s4_rh1_ff, 32'b0} + {32'b0, s4_rh0_ff};
         s5_lhs_ff  <= {s4_csq_ff, 32'b0};
         s5_nx_ff   <= s5_nxa[NUM_W-1:0];
         s5_ny_ff   <= s5_nya[NUM_W-1:0];
         s5_den_ff  <= s4_cmag_ff;
         s5_negx_ff <= s4_nx_ff[48] ^ s4_cneg_ff;
         s5_negy_ff <= s4_ny_ff[48] ^ s4_cneg_ff;
         s5_bad_ff  <= s4_bad_ff;
      end
   end

   // stage 6: parallel check, quotient overflow check
   div_req_type      s6_req_ff;
   logic [REM_W-1:0] s6_dlim;

   assign s6_dlim = {s5_den_ff, 20'b0};

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_req_ff.ok    <= !s5_bad_ff && !(s5_lhs_ff < s5_rhs_ff);
         s6_req_ff.neg_x <= s5_negx_ff;
         s6_req_ff.neg_y <= s5_negy_ff;
         s6_req_ff.ov_x  <= {4'b0, s5_nx_ff} >= s6_dlim;
         s6_req_ff.ov_y  <= {4'b0, s5_ny_ff} >= s6_dlim;
         s6_req_ff.num_x <= s5_nx_ff;
         s6_req_ff.num_y <= s5_ny_ff;
         s6_req_ff.den   <= s5_den_ff;
      end
   end

   assign out_req = s6_req_ff;

endmodule

`default_nettype wire

[src/mvjs_div.sv]
// ----------------------------------------------------------------------------
// mvjs_div: pipelined two-lane restoring divider
// resolves the 20 low quotient bits, two per stage
// ----------------------------------------------------------------------------
`default_nettype none

module mvjs_div import mvjs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output      logic        in_ready,
   input  wire div_req_type in_req,
   output      logic        out_valid,
   input  wire logic        out_ready,
   output      div_rsp_type out_rsp
);

   logic [DIV_STAGES-1:0] v_ff;
   logic [DIV_STAGES-1:0] en;
   div_lane_type          lx_ff [DIV_STAGES];
   div_lane_type          ly_ff [DIV_STAGES];
   logic [DEN_W-1:0]      den_ff [DIV_STAGES];
   logic [4:0]            flags_ff [DIV_STAGES];  // ok, neg_x, neg_y, ov_x, ov_y

   always_comb begin
      en[DIV_STAGES-1] = !v_ff[DIV_STAGES-1] || out_ready;
      for (int i = DIV_STAGES-2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[DIV_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int i = 1; i < DIV_STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   div_lane_type start_x, start_y;

   assign start_x = '{rem: in_req.num_x, quo: '0};
   assign start_y = '{rem: in_req.num_y, quo: '0};

   always_ff @(posedge clock) begin
      if (en[0]) begin
         lx_ff[0]    <= div_step(start_x, in_req.den, OUT_W - 1);
         ly_ff[0]    <= div_step(start_y, in_req.den, OUT_W - 1);
         den_ff[0]   <= in_req.den;
         flags_ff[0] <= {in_req.ok, in_req.neg_x, in_req.neg_y, in_req.ov_x, in_req.ov_y};
      end
   end

   for (genvar s = 1; s < DIV_STAGES; s++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en[s]) begin
            lx_ff[s]    <= div_step(lx_ff[s-1], den_ff[s-1], OUT_W - 1 - s * DIV_STEPS);
            ly_ff[s]    <= div_step(ly_ff[s-1], den_ff[s-1], OUT_W - 1 - s * DIV_STEPS);
            den_ff[s]   <= den_ff[s-1];
            flags_ff[s] <= flags_ff[s-1];
         end
      end
   end

   assign out_rsp.ok    = flags_ff[DIV_STAGES-1][4];
   assign out_rsp.neg_x = flags_ff[DIV_STAGES-1][3];
   assign out_rsp.neg_y = flags_ff[DIV_STAGES-1][2];
   assign out_rsp.ov_x  = flags_ff[DIV_STAGES-1][1];
   assign out_rsp.ov_y  = flags_ff[DIV_STAGES-1][0];
   assign out_rsp.quo_x = lx_ff[DIV_STAGES-1].quo;
   assign out_rsp.quo_y = ly_ff[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

[src/motion_vector_joint_solve_core.sv]
// ----------------------------------------------------------------------------
// motion_vector_joint_solve_core: joint motion vector solver
// solves m.a = |a|^2, m.b = |b|^2 by cramer's rule, q8.8 in, q11.8 out
// ----------------------------------------------------------------------------
//
//   channel  dir  tdata (low bit first)                       tuser
//   req_     in   first_x, first_y, second_x, second_y        -
//   rsp_     out  joint_x, joint_y                            solved
//   csr_     in   index 0 min_length_squared, 1 min_sine_q16  -
//
// one item per cycle sustained while rsp_ is ready; an item passes through
// 17 registers (6 product/check stages, 10 divider stages, 1 output
// register), the first of them loads at the req_ accepting edge
// the divider pipeline, two quotient bits per stage, sets the depth
// every stage has its own valid bit and loads when the stage after it
// frees up, so a stalled rsp_ side only blocks req_ once all stages are full
// reset (synchronous) empties the pipeline and restores both registers
//
`default_nettype none

module motion_vector_joint_solve_core import mvjs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [63:0] req_tdata,   // first_x, first_y, second_x, second_y
   // result items
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [39:0] rsp_tdata,   // joint_x, joint_y
   output      logic        rsp_tuser,   // solved
   // register writes
   input  wire logic        csr_we,
   input  wire logic        csr_addr,
   input  wire logic [31:0] csr_wdata
);

   // configuration registers
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_length_squared <= MIN_LENGTH_SQUARED_RESET;
         cfg_ff.min_sine_q16       <= MIN_SINE_Q16_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_MIN_LENGTH_SQUARED: cfg_ff.min_length_squared <= csr_wdata;
            CSR_MIN_SINE_Q16:       cfg_ff.min_sine_q16       <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // front stages: lengths, determinant, rejection, operand magnitudes
   logic        front_valid, front_ready;
   div_req_type front_req;

   mvjs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .ax        (req_tdata[15:0]),
      .ay        (req_tdata[31:16]),
      .bx        (req_tdata[47:32]),
      .by        (req_tdata[63:48]),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_req   (front_req)
   );

   // divider stages
   logic        div_valid, div_ready;
   div_rsp_type div_rsp;

   mvjs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_req    (front_req),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_rsp   (div_rsp)
   );

   // saturate, apply sign, zero rejected items
   function automatic logic [OUT_W-1:0] finish(input logic ok, input logic neg,
                                               input logic ov,
                                               input logic [OUT_W-1:0] quo);
      logic big;
      big = ov || quo[OUT_W-1];
      if (!ok) begin
         return '0;
      end else if (neg) begin
         return big ? OUT_MIN : OUT_W'(-quo);
      end else begin
         return big ? OUT_MAX : quo;
      end
   endfunction

   // output register
   logic        out_valid_ff;
   logic [39:0] out_data_ff;
   logic        out_solved_ff;

   assign div_ready = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (div_ready) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         out_solved_ff <= div_rsp.ok;
         out_data_ff   <= {finish(div_rsp.ok, div_rsp.neg_y, div_rsp.ov_y, div_rsp.quo_y),
                           finish(div_rsp.ok, div_rsp.neg_x, div_rsp.ov_x, div_rsp.quo_x)};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_solved_ff;

endmodule

`default_nettype wire

[src/mvjs_checker.sv]
// ----------------------------------------------------------------------------
// mvjs_checker: port-level assertions for the joint solver
// watches the result channel and reset behavior
// ----------------------------------------------------------------------------
`default_nettype none

module mvjs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   // a waiting item stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp item dropped while stalled");

   // a waiting item keeps its payload
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("rsp payload changed while stalled");

   // rejected items carry a zero vector
   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("rejected item with nonzero vector");

   // nothing comes out right after reset
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // an empty pipe takes input at once after reset
   a_ready_after_reset : assert property (@(posedge clock)
      reset ##1 !reset |-> req_tready)
      else $error("req not ready after reset");

endmodule

bind motion_vector_joint_solve_core mvjs_checker u_mvjs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

[tb/tb_motion_vector_joint_solve_core.sv]
// ----------------------------------------------------------------------------
// tb_motion_vector_joint_solve_core: self-checking bench for the joint solver
// drives vector pairs with random gaps, predicts each result in the bench and
// compares every field in order; registers are rewritten between phases
// ----------------------------------------------------------------------------
module tb_motion_vector_joint_solve_core;
   timeunit 1ns;
   timeprecision 1ps;
   import mvjs_pkg::*;

   typedef struct packed {
      logic signed [15:0] by;
      logic signed [15:0] bx;
      logic signed [15:0] ay;
      logic signed [15:0] ax;
   } pair_type;

   typedef struct packed {
      logic              solved;
      logic signed [19:0] jy;
      logic signed [19:0] jx;
   } joint_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // first_x, first_y, second_x, second_y
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // joint_x, joint_y
   logic        rsp_tuser;   // solved
   logic        csr_we;
   logic        csr_addr;
   logic [31:0] csr_wdata;

   motion_vector_joint_solve_core u_dut (.*);

   // bench copy of the two thresholds
   logic [31:0] len_sq_limit;
   logic [15:0] sine_limit;

   pair_type  pending_pairs[$];
   joint_type expected_joints[$];
   int        mismatch_count;
   int        result_count;
   int        solved_count;
   int        send_gap;
   int        recv_gap;
   bit        hold_send;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // joint vector prediction: thresholds, exact parallel test, truncating divide, saturation
   function automatic joint_type solve_pair(pair_type p);
      joint_type          r;
      longint             sa, sb, c, nx, ny, qx, qy;
      logic [127:0]       lhs, rhs;
      r  = '0;
      sa = longint'(p.ax) * p.ax + longint'(p.ay) * p.ay;
      sb = longint'(p.bx) * p.bx + longint'(p.by) * p.by;
      c  = longint'(p.ax) * p.by - longint'(p.ay) * p.bx;
      if (sa < longint'(len_sq_limit) || sb < longint'(len_sq_limit) || c == 0)
         return r;
      lhs = (128'(c < 0 ? -c : c) * 128'(c < 0 ? -c : c)) << 32;
      rhs = 128'(sine_limit) * 128'(sine_limit) * 128'(sa) * 128'(sb);
      if (lhs < rhs)
         return r;
      nx = sa * p.by - sb * p.ay;
      ny = sb * p.ax - sa * p.bx;
      qx = nx / c;
      qy = ny / c;
      if (qx > 524287) qx = 524287;
      if (qx < -524288) qx = -524288;
      if (qy > 524287) qy = 524287;
      if (qy < -524288) qy = -524288;
      r.solved = 1'b1;
      r.jx = qx[19:0];
      r.jy = qy[19:0];
      return r;
   endfunction

   // driver: one pending pair at a time, random gap drawn after each item
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (req_tvalid && !req_tready) begin
         // hold until accepted
      end else begin
         int gap;
         gap = send_gap;
         if (req_tvalid) begin
            expected_joints.push_back(solve_pair(pair_type'(req_tdata)));
            gap = ($urandom_range(0, 1) != 0) ? 0 : int'($urandom_range(0, 18));
         end
         if (gap == 0 && !hold_send && pending_pairs.size() > 0) begin
            req_tdata  <= pending_pairs.pop_front();
            req_tvalid <= 1'b1;
            send_gap   <= 0;
         end else begin
            req_tvalid <= 1'b0;
            send_gap   <= (gap > 0) ? gap - 1 : 0;
         end
      end
   end

   // monitor: random stall on the result side, field-by-field compare
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            joint_type got, want;
            int        gap;
            got = {rsp_tuser, rsp_tdata};
            result_count <= result_count + 1;
            if (expected_joints.size() == 0) begin
               mismatch_count <= mismatch_count + 1;
               if (mismatch_count < 10)
                  $display("unexpected result solved=%0d x=%0d y=%0d",
                           got.solved, got.jx, got.jy);
            end else begin
               want = expected_joints.pop_front();
               if (want.solved) solved_count <= solved_count + 1;
               if (got.solved !== want.solved || got.jx !== want.jx ||
                   got.jy !== want.jy) begin
                  mismatch_count <= mismatch_count + 1;
                  if (mismatch_count < 10)
                     $display("mismatch: expected solved=%0d x=%0d y=%0d, got solved=%0d x=%0d y=%0d",
                              want.solved, want.jx, want.jy,
                              got.solved, got.jx, got.jy);
               end
            end
            gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 18)) : 0;
            if (gap == 0) begin
               recv_gap   <= 0;
               rsp_tready <= 1'b1;
            end else begin
               recv_gap   <= gap - 1;
               rsp_tready <= 1'b0;
            end
         end else if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic wait_drained();
      while (pending_pairs.size() > 0 || req_tvalid || expected_joints.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_MIN_LENGTH_SQUARED) len_sq_limit = value;
      else sine_limit = value[15:0];
   endtask

   // random pair: mostly small well-formed vectors so many pairs solve
   function automatic pair_type random_pair();
      pair_type p;
      int       mode;
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
         p.ax = $signed(16'($urandom_range(0, 4095) - 2048));
         p.ay = $signed(16'($urandom_range(0, 4095) - 2048));
         p.bx = $signed(16'($urandom_range(0, 4095) - 2048));
         p.by = $signed(16'($urandom_range(0, 4095) - 2048));
      end else if (mode < 8) begin
         p = {$urandom, $urandom};
      end else begin
         // near parallel or extreme pairs
         p.ax = $signed(16'($urandom));
         p.ay = $signed(16'($urandom));
         p.bx = p.ax + $signed(16'($urandom_range(0, 63) - 32));
         p.by = p.ay + $signed(16'($urandom_range(0, 63) - 32));
      end
      return p;
   endfunction

   task automatic run_random(int count);
      repeat (count) pending_pairs.push_back(random_pair());
   endtask

   initial begin
      pair_type d;
      reset          = 1'b1;
      req_tdata      = '0;
      csr_we         = 1'b0;
      csr_addr       = CSR_MIN_LENGTH_SQUARED;
      csr_wdata      = '0;
      hold_send      = 1'b0;
      mismatch_count = 0;
      result_count   = 0;
      solved_count   = 0;
      len_sq_limit   = MIN_LENGTH_SQUARED_RESET;
      sine_limit     = MIN_SINE_Q16_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, orthogonal pairs, short vectors, parallel pairs
      pending_pairs.push_back({16'sd0, 16'sd256, 16'sd256, 16'sd0});
      pending_pairs.push_back({16'sd256, 16'sd256, -16'sd256, 16'sd256});
      pending_pairs.push_back({16'sd0, 16'sd10, 16'sd10, 16'sd0});       // short
      pending_pairs.push_back({16'sd512, 16'sd512, 16'sd256, 16'sd256}); // parallel
      pending_pairs.push_back({16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff});
      pending_pairs.push_back({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
      pending_pairs.push_back({16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
      pending_pairs.push_back({16'sh8000, 16'sh0000, 16'sh0000, 16'sh7fff});
      pending_pairs.push_back({16'sd300, 16'sd2000, 16'sd2100, 16'sd290}); // solved
      pending_pairs.push_back({-16'sd300, 16'sd2000, 16'sd2100, -16'sd290});
      pending_pairs.push_back({16'sd0, 16'sd0, 16'sd256, 16'sd0});
      pending_pairs.push_back({16'sd1, 16'sd1, -16'sd1, 16'sd1});
      run_random(500);
      // part way through, the sender holds off until everything has come back
      while (pending_pairs.size() > 250)
         @(posedge clock);
      hold_send = 1'b1;
      while (req_tvalid || expected_joints.size() > 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
      hold_send = 1'b0;
      wait_drained();

      // zero thresholds: tiny vectors reach the divider, zero determinant is still rejected
      write_reg(CSR_MIN_LENGTH_SQUARED, 32'd0);
      write_reg(CSR_MIN_SINE_Q16, 32'd0);
      pending_pairs.push_back('0);
      pending_pairs.push_back({16'sd2, 16'sd2, 16'sd1, 16'sd1});
      pending_pairs.push_back({16'sd1, 16'sd0, 16'sd0, 16'sd1});
      run_random(500);
      wait_drained();

      // maximal thresholds: everything is rejected
      write_reg(CSR_MIN_LENGTH_SQUARED, 32'hffff_ffff);
      write_reg(CSR_MIN_SINE_Q16, 32'h0000_ffff);
      run_random(200);
      wait_drained();

      // mid settings with random bits
      write_reg(CSR_MIN_LENGTH_SQUARED, $urandom_range(0, 65535));
      write_reg(CSR_MIN_SINE_Q16, $urandom_range(0, 40000));
      run_random(400);
      wait_drained();
      write_reg(CSR_MIN_LENGTH_SQUARED, MIN_LENGTH_SQUARED_RESET);
      write_reg(CSR_MIN_SINE_Q16, 32'hffff_0000 | 32'd65535);
      run_random(100);
      wait_drained();
      write_reg(CSR_MIN_SINE_Q16, MIN_SINE_Q16_RESET);
      run_random(300);
      wait_drained();

      $display("covered %0d results, %0d solved, across six threshold settings",
               result_count, solved_count);
      if (mismatch_count == 0 && expected_joints.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end
endmodule
